/* hdl/bernoulli_polynomial_eval_assert.svh */
// ============================================================================
// Assertion macros for the Bernoulli polynomial evaluator
// Shared concurrent assertion forms, clocked on the rising edge and disabled
// while reset is asserted.
// ============================================================================
`ifndef BERNOULLI_POLYNOMIAL_EVAL_ASSERT_SVH
`define BERNOULLI_POLYNOMIAL_EVAL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPE_ASSERT_IMPLIES(name, clock, resetn, ante, cons, msg) \
    name: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error(msg);

// The condition must hold at every clock edge outside reset.
`define BPE_ASSERT_ALWAYS(name, clock, resetn, cond, msg) \
    name: assert property (@(posedge clock) disable iff (!resetn) (cond)) \
        else $error(msg);

`endif

/* hdl/bpe_pkg.sv */
// ============================================================================
// Bernoulli polynomial evaluator package
// Types, fixed-point constants and coefficient tables of the Horner datapath.
// ============================================================================
package bpe_pkg;

    localparam int X_FRAC_BITS_DEF = 32;
    localparam int MODE_W          = 4;
    localparam int X_W             = 32;
    localparam int VALUE_W         = 48;
    localparam int OUT_FRAC        = 40;
    localparam int QF              = 52;
    localparam int MAG_W           = 56;
    localparam int T_W             = MAG_W + 1;
    localparam int OUT_SHIFT       = QF - OUT_FRAC;
    localparam int MAX_DEGREE      = 8;
    localparam int NUM_STEPS       = 7;
    localparam int STEP_W          = 3;

    // Q.52 constants, nearest value with halves rounded up.
    localparam logic signed [T_W-1:0] C_HALF  = T_W'(((64'd1  << QF) + 64'd1)  / 64'd2);
    localparam logic signed [T_W-1:0] C_ONE   = T_W'(((64'd1  << QF) + 64'd0)  / 64'd1);
    localparam logic signed [T_W-1:0] C_3_2   = T_W'(((64'd3  << QF) + 64'd1)  / 64'd2);
    localparam logic signed [T_W-1:0] C_TWO   = T_W'(((64'd2  << QF) + 64'd0)  / 64'd1);
    localparam logic signed [T_W-1:0] C_5_2   = T_W'(((64'd5  << QF) + 64'd1)  / 64'd2);
    localparam logic signed [T_W-1:0] C_THREE = T_W'(((64'd3  << QF) + 64'd0)  / 64'd1);
    localparam logic signed [T_W-1:0] C_7_2   = T_W'(((64'd7  << QF) + 64'd1)  / 64'd2);
    localparam logic signed [T_W-1:0] C_FOUR  = T_W'(((64'd4  << QF) + 64'd0)  / 64'd1);
    localparam logic signed [T_W-1:0] C_1_6   = T_W'(((64'd1  << QF) + 64'd3)  / 64'd6);
    localparam logic signed [T_W-1:0] C_1_30  = T_W'(((64'd1  << QF) + 64'd15) / 64'd30);
    localparam logic signed [T_W-1:0] C_1_42  = T_W'(((64'd1  << QF) + 64'd21) / 64'd42);
    localparam logic signed [T_W-1:0] C_5_3   = T_W'(((64'd5  << QF) + 64'd1)  / 64'd3);
    localparam logic signed [T_W-1:0] C_7_6   = T_W'(((64'd7  << QF) + 64'd3)  / 64'd6);
    localparam logic signed [T_W-1:0] C_7_3   = T_W'(((64'd7  << QF) + 64'd1)  / 64'd3);
    localparam logic signed [T_W-1:0] C_14_3  = T_W'(((64'd14 << QF) + 64'd1)  / 64'd3);
    localparam logic signed [T_W-1:0] C_2_3   = T_W'(((64'd2  << QF) + 64'd1)  / 64'd3);

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [X_W-1:0]    x_frac;
    } bpe_in_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      error;
    } bpe_out_t;

    // One item in flight: degree and the running Horner value as sign and magnitude.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              neg;
        logic [MAG_W-1:0]  mag;
    } bpe_item_t;

    // Number of multiply steps the degree needs; they occupy the last steps of the pipe.
    function automatic logic [STEP_W-1:0] step_count(input logic [MODE_W-1:0] mode);
        logic [STEP_W-1:0] n;
        case (mode)
            4'd2:    n = 3'd1;
            4'd3:    n = 3'd2;
            4'd4:    n = 3'd3;
            4'd5:    n = 3'd4;
            4'd6:    n = 3'd5;
            4'd7:    n = 3'd6;
            4'd8:    n = 3'd7;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    // Constant subtracted from x to form the innermost Horner term.
    function automatic logic signed [T_W-1:0] start_const(input logic [MODE_W-1:0] mode);
        logic signed [T_W-1:0] c;
        case (mode)
            4'd1:    c = C_HALF;
            4'd2:    c = C_ONE;
            4'd3:    c = C_3_2;
            4'd4:    c = C_TWO;
            4'd5:    c = C_5_2;
            4'd6:    c = C_THREE;
            4'd7:    c = C_7_2;
            4'd8:    c = C_FOUR;
            default: c = '0;
        endcase
        return c;
    endfunction

    // Constant added after the product of a given pipeline step.
    function automatic logic signed [T_W-1:0] step_const(input logic [MODE_W-1:0] mode,
                                                        input logic [STEP_W-1:0] step);
        logic [STEP_W-1:0]     pos;
        logic signed [T_W-1:0] c;
        pos = step + step_count(mode) - STEP_W'(NUM_STEPS);
        c   = '0;
        case (mode)
            4'd2:
            begin
                case (pos)
                    3'd1:    c = C_1_6;
                    default: c = '0;
                endcase
            end
            4'd3:
            begin
                case (pos)
                    3'd1:    c = C_HALF;
                    default: c = '0;
                endcase
            end
            4'd4:
            begin
                case (pos)
                    3'd1:    c = C_ONE;
                    3'd3:    c = -C_1_30;
                    default: c = '0;
                endcase
            end
            4'd5:
            begin
                case (pos)
                    3'd1:    c = C_5_3;
                    3'd3:    c = -C_1_6;
                    default: c = '0;
                endcase
            end
            4'd6:
            begin
                case (pos)
                    3'd1:    c = C_5_2;
                    3'd3:    c = -C_HALF;
                    3'd5:    c = C_1_42;
                    default: c = '0;
                endcase
            end
            4'd7:
            begin
                case (pos)
                    3'd1:    c = C_7_2;
                    3'd3:    c = -C_7_6;
                    3'd5:    c = C_1_6;
                    default: c = '0;
                endcase
            end
            4'd8:
            begin
                case (pos)
                    3'd1:    c = C_14_3;
                    3'd3:    c = -C_7_3;
                    3'd5:    c = C_2_3;
                    3'd7:    c = -C_1_30;
                    default: c = '0;
                endcase
            end
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

/* hdl/bpe_horner_step.sv */
// ============================================================================
// Horner step of the Bernoulli polynomial evaluator
// Three stages: partial products of |t| times x, sum and rounding, then the
// signed add of the step constant. Steps a degree does not use pass t through.
// ============================================================================
`include "bernoulli_polynomial_eval_assert.svh"

module bpe_horner_step #(
    parameter int X_FRAC_BITS = bpe_pkg::X_FRAC_BITS_DEF,
    parameter int STEP        = bpe_pkg::NUM_STEPS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   src_valid,
    output logic                   src_stall,
    input  bpe_pkg::bpe_item_t     src_item,
    input  logic [X_FRAC_BITS-1:0] src_x,
    output logic                   dst_valid,
    input  logic                   dst_stall,
    output bpe_pkg::bpe_item_t     dst_item,
    output logic [X_FRAC_BITS-1:0] dst_x
);
    import bpe_pkg::*;

    localparam int XLO_W  = (X_FRAC_BITS + 1) / 2;
    localparam int XHI_W  = X_FRAC_BITS - XLO_W;
    localparam int MLO_W  = MAG_W / 2;
    localparam int MHI_W  = MAG_W - MLO_W;
    localparam int PROD_W = MAG_W + X_FRAC_BITS + 1;

    logic                      m_valid_reg;
    bpe_item_t                 m_item_reg;
    logic [X_FRAC_BITS-1:0]    m_x_reg;
    logic [MLO_W+XLO_W-1:0]    pp_ll_reg;
    logic [MLO_W+XHI_W-1:0]    pp_lh_reg;
    logic [MHI_W+XLO_W-1:0]    pp_hl_reg;
    logic [MHI_W+XHI_W-1:0]    pp_hh_reg;

    logic                      s_valid_reg;
    bpe_item_t                 s_item_reg;
    logic [X_FRAC_BITS-1:0]    s_x_reg;
    logic [MAG_W-1:0]          s_prod_reg;

    logic                      c_valid_reg;
    bpe_item_t                 c_item_reg;
    logic [X_FRAC_BITS-1:0]    c_x_reg;

    logic                      adv_m;
    logic                      adv_s;
    logic                      adv_c;
    logic [PROD_W-1:0]         prod_sum;
    logic [MAG_W-1:0]          s_prod_next;
    logic                      step_on;
    logic signed [T_W-1:0]     step_c;
    logic signed [T_W-1:0]     prod_s;
    logic signed [T_W-1:0]     horner_sum;
    logic signed [T_W-1:0]     horner_abs;
    bpe_item_t                 c_item_next;

    // A stage moves when it is empty or the stage after it moves.
    assign adv_c     = !c_valid_reg || !dst_stall;
    assign adv_s     = !s_valid_reg || adv_c;
    assign adv_m     = !m_valid_reg || adv_s;
    assign src_stall = !adv_m;

    // Product of |t| and x, rounded to nearest at the x fraction point.
    assign prod_sum = PROD_W'(pp_ll_reg)
                    + (PROD_W'(pp_lh_reg) << XLO_W)
                    + (PROD_W'(pp_hl_reg) << MLO_W)
                    + (PROD_W'(pp_hh_reg) << (MLO_W + XLO_W))
                    + (PROD_W'(1) << (X_FRAC_BITS - 1));
    assign s_prod_next = prod_sum[X_FRAC_BITS +: MAG_W];

    assign step_on = ({1'b0, step_count(s_item_reg.mode)} + (STEP_W + 1)'(STEP))
                     > (STEP_W + 1)'(NUM_STEPS);
    assign step_c  = step_const(s_item_reg.mode, STEP_W'(STEP));
    assign prod_s  = T_W'(s_prod_reg);

    always_comb
    begin
        horner_sum       = s_item_reg.neg ? (step_c - prod_s) : (step_c + prod_s);
        horner_abs       = horner_sum[T_W-1] ? -horner_sum : horner_sum;
        c_item_next.mode = s_item_reg.mode;
        if (step_on)
        begin
            c_item_next.neg = horner_sum[T_W-1];
            c_item_next.mag = horner_abs[MAG_W-1:0];
        end
        else
        begin
            c_item_next.neg = s_item_reg.neg;
            c_item_next.mag = s_item_reg.mag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_m)
            begin
                m_valid_reg <= src_valid;
            end
            if (adv_s)
            begin
                s_valid_reg <= m_valid_reg;
            end
            if (adv_c)
            begin
                c_valid_reg <= s_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_m)
        begin
            m_item_reg <= src_item;
            m_x_reg    <= src_x;
            pp_ll_reg  <= src_item.mag[MLO_W-1:0]     * src_x[XLO_W-1:0];
            pp_lh_reg  <= src_item.mag[MLO_W-1:0]     * src_x[X_FRAC_BITS-1:XLO_W];
            pp_hl_reg  <= src_item.mag[MAG_W-1:MLO_W] * src_x[XLO_W-1:0];
            pp_hh_reg  <= src_item.mag[MAG_W-1:MLO_W] * src_x[X_FRAC_BITS-1:XLO_W];
        end
        if (adv_s)
        begin
            s_item_reg <= m_item_reg;
            s_x_reg    <= m_x_reg;
            s_prod_reg <= s_prod_next;
        end
        if (adv_c)
        begin
            c_item_reg <= c_item_next;
            c_x_reg    <= s_x_reg;
        end
    end

    assign dst_valid = c_valid_reg;
    assign dst_item  = c_item_reg;
    assign dst_x     = c_x_reg;

    // Since x is below one, the rounded product never exceeds the incoming magnitude.
    `BPE_ASSERT_IMPLIES(a_prod_bound, clk, rst_n, s_valid_reg, s_prod_reg <= s_item_reg.mag, "product exceeds operand")
    // Upstream is held off only while the multiply stage holds a transaction.
    `BPE_ASSERT_IMPLIES(a_stall_source, clk, rst_n, src_stall, m_valid_reg, "stall without a held transaction")
    // The running value keeps one bit of headroom in its magnitude.
    `BPE_ASSERT_IMPLIES(a_headroom, clk, rst_n, c_valid_reg, !c_item_reg.mag[MAG_W-1], "running value overflow")

endmodule

/* hdl/bernoulli_polynomial_eval.sv */
// ============================================================================
// Bernoulli polynomial evaluator
// Returns B_n(x) for degrees 0 to 8 at a point x in [0,1), as a signed value
// with 40 fraction bits, through a pipelined nested Horner datapath.
// ============================================================================
//
//   Channel   Signals                              Carries
//   item      item_valid, item_stall, item         degree and x fraction
//   result    result_valid, result_stall, result   B_n(x) and error flag
//
// One transaction is accepted per cycle when the result side keeps up.
// The path is an entry register, seven Horner steps of three stages each
// (partial products, sum and round, constant add), and an output register.
// Reset clears only the valid bits; all payload registers are left as they are.
// A stall on the result side holds each stage only once the stage after it is
// full, so empty stages keep filling and item_stall rises last.
//
`include "bernoulli_polynomial_eval_assert.svh"

module bernoulli_polynomial_eval #(
    parameter int X_FRAC_BITS = bpe_pkg::X_FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  bpe_pkg::bpe_in_t  item,
    output logic              result_valid,
    input  logic              result_stall,
    output bpe_pkg::bpe_out_t result
);
    import bpe_pkg::*;

    // Entry stage: x is placed at the Q.52 point and the innermost term x - a
    // is formed. Degree zero enters as the constant one and skips every step.
    logic [X_W+X_FRAC_BITS-1:0] x_ext;
    logic [X_FRAC_BITS-1:0]     x_in;
    logic signed [T_W-1:0]      x_q;
    logic signed [T_W-1:0]      t0;
    logic signed [T_W-1:0]      t0_abs;
    bpe_item_t                  e_item_next;

    logic                       e_valid_reg;
    bpe_item_t                  e_item_reg;
    logic [X_FRAC_BITS-1:0]     e_x_reg;
    logic                       adv_e;

    // Links between the stages: link k is the output of step k, link 0 the entry.
    logic                       link_valid [0:NUM_STEPS];
    logic                       link_stall [0:NUM_STEPS];
    bpe_item_t                  link_item  [0:NUM_STEPS];
    logic [X_FRAC_BITS-1:0]     link_x     [0:NUM_STEPS-1];

    // Output stage: round Q.52 to Q.40, halves away from zero, and apply the sign.
    logic                       adv_o;
    logic [MAG_W:0]             round_mag;
    logic [MAG_W-OUT_SHIFT:0]   out_mag;
    bpe_out_t                   result_next;
    logic                       result_valid_reg;
    bpe_out_t                   result_reg;

    assign x_ext = {{X_FRAC_BITS{1'b0}}, item.x_frac};
    assign x_in  = x_ext[X_FRAC_BITS-1:0];
    assign x_q   = T_W'({x_in, {(QF - X_FRAC_BITS){1'b0}}});

    always_comb
    begin
        t0               = x_q - start_const(item.mode);
        t0_abs           = t0[T_W-1] ? -t0 : t0;
        e_item_next.mode = item.mode;
        if (item.mode == '0)
        begin
            e_item_next.neg = 1'b0;
            e_item_next.mag = C_ONE[MAG_W-1:0];
        end
        else
        begin
            e_item_next.neg = t0[T_W-1];
            e_item_next.mag = t0_abs[MAG_W-1:0];
        end
    end

    assign adv_e      = !e_valid_reg || !link_stall[0];
    assign item_stall = !adv_e;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else if (adv_e)
        begin
            e_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_e)
        begin
            e_item_reg <= e_item_next;
            e_x_reg    <= x_in;
        end
    end

    assign link_valid[0] = e_valid_reg;
    assign link_item[0]  = e_item_reg;
    assign link_x[0]     = e_x_reg;

    // Seven multiply-and-add steps. A degree with k steps uses the last k of
    // them, so every result leaves the chain at the same depth.
    for (genvar k = 1; k <= NUM_STEPS; k++)
    begin : g_step
        if (k < NUM_STEPS)
        begin : g_mid
            bpe_horner_step #(
                .X_FRAC_BITS (X_FRAC_BITS),
                .STEP        (k)
            ) u_step (
                .clk       (clk),
                .rst_n     (rst_n),
                .src_valid (link_valid[k-1]),
                .src_stall (link_stall[k-1]),
                .src_item  (link_item[k-1]),
                .src_x     (link_x[k-1]),
                .dst_valid (link_valid[k]),
                .dst_stall (link_stall[k]),
                .dst_item  (link_item[k]),
                .dst_x     (link_x[k])
            );
        end
        else
        begin : g_last
            bpe_horner_step #(
                .X_FRAC_BITS (X_FRAC_BITS),
                .STEP        (k)
            ) u_step (
                .clk       (clk),
                .rst_n     (rst_n),
                .src_valid (link_valid[k-1]),
                .src_stall (link_stall[k-1]),
                .src_item  (link_item[k-1]),
                .src_x     (link_x[k-1]),
                .dst_valid (link_valid[k]),
                .dst_stall (link_stall[k]),
                .dst_item  (link_item[k]),
                .dst_x     ()
            );
        end
    end

    assign adv_o                 = !result_valid_reg || !result_stall;
    assign link_stall[NUM_STEPS] = !adv_o;

    always_comb
    begin
        round_mag = (MAG_W + 1)'(link_item[NUM_STEPS].mag) + ((MAG_W + 1)'(1) << (OUT_SHIFT - 1));
        out_mag   = round_mag[MAG_W:OUT_SHIFT];
        if (link_item[NUM_STEPS].mode > MODE_W'(MAX_DEGREE))
        begin
            // Degree out of range: zero value with the error flag.
            result_next.value = '0;
            result_next.error = 1'b1;
        end
        else
        begin
            result_next.value = link_item[NUM_STEPS].neg ? -VALUE_W'(out_mag)
                                                         : VALUE_W'(out_mag);
            result_next.error = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (adv_o)
        begin
            result_valid_reg <= link_valid[NUM_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_o)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // With the result side open, every stage can move, so the input is open too.
    `BPE_ASSERT_IMPLIES(a_open_path, clk, rst_n, !result_stall, !item_stall, "input stalled with open output")
    // An out-of-range degree always yields a zero value.
    `BPE_ASSERT_IMPLIES(a_error_zero, clk, rst_n, result_valid && result.error, result.value == '0, "error result not zero")
    // Every Bernoulli polynomial of degree 0 to 8 stays within [-1, 1] on [0,1).
    `BPE_ASSERT_IMPLIES(a_value_range, clk, rst_n, result_valid, (result.value[VALUE_W-1:OUT_FRAC+1] == '0) || (result.value[VALUE_W-1:OUT_FRAC+1] == '1), "value out of range")

endmodule

/* bench/tb_top.sv */
// ============================================================================
// Testbench for the Bernoulli polynomial evaluator
// Drives degree and x transactions into the block and predicts each B_n(x)
// with a bit-exact Q.52 Horner model of its own. Each result is compared
// with the oldest outstanding prediction. Both sides idle and stall at random.
// ============================================================================
module tb_top;

    import bpe_pkg::bpe_in_t;
    import bpe_pkg::bpe_out_t;

    localparam int CLK_PERIOD      = 8;
    localparam int RESET_CYCLES    = 7;
    // Highest degree with a defined polynomial; anything above is an error.
    localparam int TOP_DEGREE      = 8;
    localparam int DEGREE_LAST     = 15;
    // Datapath format: Q.52 internally, 32-bit x fraction, Q.40 result.
    localparam int Q_FRAC          = 52;
    localparam int X_BITS          = 32;
    localparam int RESULT_FRAC     = 40;
    localparam int X_SHIFT         = Q_FRAC - X_BITS;
    localparam int ROUND_SHIFT     = Q_FRAC - RESULT_FRAC;
    // The tail wait outlasts the block's pipe and leaves a margin on top.
    localparam int DRAIN_CYCLES    = 40;
    localparam int HOLD_CYCLES     = 120;
    localparam int WATCHDOG_CYCLES = 200000;

    typedef logic signed [63:0] q52_t;

    // One outstanding transaction: what went in and what must come out.
    typedef struct packed {
        bpe_in_t  src;
        bpe_out_t want;
    } pending_t;

    logic     clk;
    logic     rst_n;
    logic     item_valid;
    logic     item_stall;
    bpe_in_t  item;
    logic     result_valid;
    logic     result_stall;
    bpe_out_t result;

    // Predictions wait here in acceptance order until the block answers.
    pending_t pending[$];
    int       mismatch_count = 0;
    // Random idling on the input side and random stalls on the output side.
    bit       send_idle_on   = 1'b0;
    bit       recv_idle_on   = 1'b0;
    // Cycles of forced output stall, counted down by the result sink.
    int       stall_hold     = 0;

    bernoulli_polynomial_eval i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // The run must end on its own well before this; reaching it means a hang.
    initial
    begin : watchdog
        #(WATCHDOG_CYCLES * CLK_PERIOD);
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Fixed-point model of the Horner datapath
    // ------------------------------------------------------------------------

    // Nearest Q.52 value to num/den, halves rounded up.
    function automatic q52_t q52_of(input int unsigned num, input int unsigned den);
        logic [63:0] scaled;
        scaled = ((64'(num) << Q_FRAC) + 64'(den / 2)) / 64'(den);
        return $signed(scaled);
    endfunction

    // Exact product of two Q.52 values, rounded back to Q.52 with halves away
    // from zero. The work is done on magnitudes so the rounding is symmetric.
    function automatic q52_t q52_mul(input q52_t a, input q52_t b);
        logic [127:0] full;
        logic [63:0]  mag_a;
        logic [63:0]  mag_b;
        logic [63:0]  mag_p;
        logic         neg;
        neg   = (a < 0) != (b < 0);
        mag_a = (a < 0) ? 64'(-a) : 64'(a);
        mag_b = (b < 0) ? 64'(-b) : 64'(b);
        full  = {64'd0, mag_a} * {64'd0, mag_b};
        full  = full + (128'd1 << (Q_FRAC - 1));
        mag_p = {1'b0, full[Q_FRAC+62:Q_FRAC]};
        return neg ? -$signed(mag_p) : $signed(mag_p);
    endfunction

    // B_n(x) in Q.52 through the nested Horner forms, one product at a time
    // in the same order as the hardware so every rounding lines up.
    function automatic q52_t bernoulli_q52(input logic [3:0] degree, input q52_t x);
        q52_t acc;
        case (degree)
            4'd0: acc = q52_of(1, 1);
            4'd1: acc = x - q52_of(1, 2);
            4'd2: acc = q52_mul(x, x - q52_of(1, 1)) + q52_of(1, 6);
            4'd3:
            begin
                acc = q52_mul(x - q52_of(3, 2), x) + q52_of(1, 2);
                acc = q52_mul(acc, x);
            end
            4'd4:
            begin
                acc = q52_mul(x - q52_of(2, 1), x) + q52_of(1, 1);
                acc = q52_mul(q52_mul(acc, x), x) - q52_of(1, 30);
            end
            4'd5:
            begin
                acc = q52_mul(x - q52_of(5, 2), x) + q52_of(5, 3);
                acc = q52_mul(q52_mul(acc, x), x) - q52_of(1, 6);
                acc = q52_mul(acc, x);
            end
            4'd6:
            begin
                acc = q52_mul(x - q52_of(3, 1), x) + q52_of(5, 2);
                acc = q52_mul(q52_mul(acc, x), x) - q52_of(1, 2);
                acc = q52_mul(q52_mul(acc, x), x) + q52_of(1, 42);
            end
            4'd7:
            begin
                acc = q52_mul(x - q52_of(7, 2), x) + q52_of(7, 2);
                acc = q52_mul(q52_mul(acc, x), x) - q52_of(7, 6);
                acc = q52_mul(q52_mul(acc, x), x) + q52_of(1, 6);
                acc = q52_mul(acc, x);
            end
            default:
            begin
                acc = q52_mul(x - q52_of(4, 1), x) + q52_of(14, 3);
                acc = q52_mul(q52_mul(acc, x), x) - q52_of(7, 3);
                acc = q52_mul(q52_mul(acc, x), x) + q52_of(2, 3);
                acc = q52_mul(q52_mul(acc, x), x) - q52_of(1, 30);
            end
        endcase
        return acc;
    endfunction

    // Full expected result for one input transaction. Degrees above the top
    // one give a zero value with the error flag; the rest are rounded from
    // Q.52 to Q.40, halves away from zero, and cut to the output width.
    function automatic bpe_out_t predict_bernoulli(input bpe_in_t src);
        bpe_out_t    want;
        q52_t        x;
        q52_t        v;
        q52_t        rounded;
        logic [63:0] mag;
        if (src.mode > TOP_DEGREE)
        begin
            want.value = '0;
            want.error = 1'b1;
        end
        else
        begin
            x       = $signed(64'(src.x_frac) << X_SHIFT);
            v       = bernoulli_q52(src.mode, x);
            mag     = (v < 0) ? 64'(-v) : 64'(v);
            mag     = (mag + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
            mag[63] = 1'b0;
            rounded = (v < 0) ? -$signed(mag) : $signed(mag);
            want.value = rounded[47:0];
            want.error = 1'b0;
        end
        return want;
    endfunction

    // ------------------------------------------------------------------------
    // Shared driving, sinking and checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    // Offers one transaction and holds it until accepted. Entered just after
    // a falling edge and returns just after one, with valid still high so
    // back-to-back calls keep the input busy every cycle while idling is off.
    task automatic send_item(input logic [3:0] degree, input logic [31:0] xf);
        pending_t entry;
        if (send_idle_on && $urandom_range(0, 5) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        entry.src.mode   = degree;
        entry.src.x_frac = xf;
        entry.want       = predict_bernoulli(entry.src);
        item_valid <= 1'b1;
        item       <= entry.src;
        do
            @(posedge clk);
        while (item_stall);
        pending.push_back(entry);
        @(negedge clk);
    endtask

    // Random transaction. Most degrees are valid; the x patterns lean toward
    // the ends of [0,1), the midpoint and single bits next to plain random.
    task automatic send_random_item();
        logic [3:0]  degree;
        logic [31:0] xf;
        if ($urandom_range(0, 9) == 0)
            degree = 4'($urandom_range(TOP_DEGREE + 1, DEGREE_LAST));
        else
            degree = 4'($urandom_range(0, TOP_DEGREE));
        case ($urandom_range(0, 9))
            0:       xf = $urandom_range(0, 255);
            1:       xf = 32'hFFFF_FFFF - $urandom_range(0, 255);
            2:       xf = 32'h8000_0000 ^ $urandom_range(0, 255);
            3:       xf = 32'd1 << $urandom_range(0, 31);
            default: xf = $urandom;
        endcase
        send_item(degree, xf);
    endtask

    // Drops valid and waits until every outstanding transaction has returned.
    task automatic wait_all_results();
        item_valid <= 1'b0;
        while (pending.size() != 0)
            @(negedge clk);
    endtask

    // Output side: a forced hold when one is requested, otherwise random
    // stall bursts while they are enabled. Changes only at falling edges.
    initial
    begin : result_sink
        int burst;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_hold > 0)
            begin
                result_stall <= 1'b1;
                stall_hold = stall_hold - 1;
            end
            else if (recv_idle_on && $urandom_range(0, 7) == 0)
            begin
                burst = $urandom_range(1, 10);
                result_stall <= 1'b1;
                repeat (burst - 1) @(negedge clk);
            end
            else
                result_stall <= 1'b0;
        end
    end

    // Every accepted result transaction is matched against the oldest
    // prediction, field by field.
    always @(posedge clk)
    begin : result_monitor
        pending_t head;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending.size() == 0)
                report_mismatch($sformatf("unexpected result value=%h error=%b",
                                          result.value, result.error));
            else
            begin
                head = pending.pop_front();
                if (result.value !== head.want.value)
                    report_mismatch($sformatf("degree %0d x=%h: value %h, want %h",
                                              head.src.mode, head.src.x_frac,
                                              result.value, head.want.value));
                if (result.error !== head.want.error)
                    report_mismatch($sformatf("degree %0d x=%h: error %b, want %b",
                                              head.src.mode, head.src.x_frac,
                                              result.error, head.want.error));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Every valid degree at x = 0 and at the largest x, then every error
    // degree with x alternating between all zeros and all ones.
    task automatic test_degree_extremes();
        for (int d = 0; d <= TOP_DEGREE; d++)
        begin
            send_item(4'(d), 32'h0000_0000);
            send_item(4'(d), 32'hFFFF_FFFF);
        end
        for (int d = TOP_DEGREE + 1; d <= DEGREE_LAST; d++)
            send_item(4'(d), (d % 2 == 1) ? 32'hFFFF_FFFF : 32'h0000_0000);
        wait_all_results();
    endtask

    // Long random stream with idling bursts on both sides.
    task automatic test_random_stream(input int count);
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        repeat (count) send_random_item();
        wait_all_results();
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
    endtask

    // The output is held off for a long stretch while transactions keep
    // coming, so the pipe fills and the block must stall its input. The
    // sender then pauses until every result has drained.
    task automatic test_backpressure(input int count);
        stall_hold = HOLD_CYCLES;
        repeat (count) send_random_item();
        wait_all_results();
    endtask

    // Back to back at full rate with no idling on either side.
    task automatic test_full_rate(input int count);
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        repeat (count) send_random_item();
        item_valid <= 1'b0;
    endtask

    initial
    begin
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_degree_extremes();
        test_random_stream(520);
        test_backpressure(60);
        test_random_stream(60);
        test_full_rate(200);

        // Let the pipe empty, then watch a little longer for stray results.
        while (pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
